// ===== rtl/core/rse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI squared error statistics - shared package
// Payload structs, register indexes, defaults and widths.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int MaxDimDefault    = 4096;
  localparam int PixelBitsDefault = 8;

  localparam logic [1:0] REG_ROW_START = 2'd0;
  localparam logic [1:0] REG_COL_START = 2'd1;
  localparam logic [1:0] REG_ROW_END   = 2'd2;
  localparam logic [1:0] REG_COL_END   = 2'd3;

  localparam logic [11:0] ROW_START_RST = 12'd50;
  localparam logic [11:0] COL_START_RST = 12'd150;
  localparam logic [12:0] ROW_END_RST   = 13'd450;
  localparam logic [12:0] COL_END_RST   = 13'd350;

  typedef struct packed {
    logic [7:0]  truth_pixel;
    logic [7:0]  test_pixel;
    logic [11:0] row;
    logic [11:0] col;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic        is_summary;
    logic [15:0] sq_error;
    logic [23:0] mean_q8;
    logic [47:0] variance_q8;
    logic [24:0] mismatch_count;
    logic [16:0] error_rate_q16;
    logic        roi_invalid;
    logic        last;
  } out_item_t;

  // frame totals handed from the front end to the back end
  typedef struct packed {
    logic [39:0] sum;
    logic [56:0] sumsq;
    logic [24:0] count;
    logic [24:0] area;
    logic        invalid;
  } frame_tot_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_MUL,
    BE_DIV,
    BE_OUT
  } be_state_t;

endpackage

// ===== rtl/core/rse_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI squared error statistics - serial divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rse_divider #(
  parameter int NumW = 128,
  parameter int DenW = 50
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            done,
  output logic [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] shreg;
  logic [DenW:0]   rem;
  logic [DenW-1:0] dreg;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [DenW:0]   trial;

  assign trial = {rem[DenW-1:0], shreg[NumW-1]};
  assign quo   = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= num;
        dreg  <= den;
        rem   <= '0;
        cnt   <= CntW'(NumW);
      end else if (busy) begin
        // shift one numerator bit in, subtract when it fits
        if (trial >= {1'b0, dreg}) begin
          rem   <= trial - {1'b0, dreg};
          shreg <= {shreg[NumW-2:0], 1'b1};
        end else begin
          rem   <= trial;
          shreg <= {shreg[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/core/rse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI squared error statistics - front end
// Region test, squared error, accumulation and pixel results.
// ----------------------------------------------------------------------------
module rse_front #(
  parameter int MaxDim    = rse_pkg::MaxDimDefault,
  parameter int PixelBits = rse_pkg::PixelBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rse_pkg::in_item_t   in_item,
  input  logic [11:0]         row_start,
  input  logic [11:0]         col_start,
  input  logic [12:0]         row_end,
  input  logic [12:0]         col_end,
  output logic                pix_valid,
  output logic [15:0]         pix_sq,
  output logic                pix_fend,
  output logic                tot_valid,
  output rse_pkg::frame_tot_t tot
);
  localparam logic [12:0] DimLim = 13'(MaxDim);

  logic [PixelBits-1:0] a, b, d;
  logic [12:0] re, ce;
  logic        in_roi;
  logic [15:0] sq;
  logic [31:0] sq2;
  logic [39:0] sum, sum_next;
  logic [56:0] sumsq, sumsq_next;
  logic [24:0] count, count_next;
  logic [12:0] dr, dc;
  logic        inv;

  assign a  = in_item.truth_pixel[PixelBits-1:0];
  assign b  = in_item.test_pixel[PixelBits-1:0];
  assign d  = (a >= b) ? a - b : b - a;
  assign re = (row_end > DimLim) ? DimLim : row_end;
  assign ce = (col_end > DimLim) ? DimLim : col_end;
  assign in_roi = ({1'b0, in_item.row} >= {1'b0, row_start}) && ({1'b0, in_item.row} < re)
               && ({1'b0, in_item.col} >= {1'b0, col_start}) && ({1'b0, in_item.col} < ce);
  assign sq  = in_roi ? 16'(d) * 16'(d) : 16'd0;
  assign sq2 = 32'(sq) * 32'(sq);

  assign sum_next   = sum + 40'(sq);
  assign sumsq_next = sumsq + 57'(sq2);
  assign count_next = count + 25'(in_roi && (d != '0));

  assign inv = (re <= {1'b0, row_start}) || (ce <= {1'b0, col_start});
  assign dr  = re - {1'b0, row_start};
  assign dc  = ce - {1'b0, col_start};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      sumsq     <= '0;
      count     <= '0;
      pix_valid <= 1'b0;
      tot_valid <= 1'b0;
    end else begin
      pix_valid <= in_valid;
      tot_valid <= in_valid && in_item.frame_end;
      if (in_valid) begin
        if (in_item.frame_end) begin
          sum   <= '0;
          sumsq <= '0;
          count <= '0;
        end else begin
          sum   <= sum_next;
          sumsq <= sumsq_next;
          count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pix_sq      <= sq;
    pix_fend    <= in_item.frame_end;
    tot.sum     <= sum_next;
    tot.sumsq   <= sumsq_next;
    tot.count   <= count_next;
    tot.invalid <= inv;
    tot.area    <= inv ? 25'd0 : 25'(26'(dr) * 26'(dc));
  end
endmodule

// ===== rtl/core/rse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI squared error statistics - back end
// Mean, variance and rate of one frame through one shared divider.
// ----------------------------------------------------------------------------
module rse_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                tot_valid,
  input  rse_pkg::frame_tot_t tot,
  output logic                busy,
  output logic                sum_valid,
  output rse_pkg::out_item_t  sum_item,
  input  logic                sum_taken
);
  rse_pkg::be_state_t state, state_next;
  rse_pkg::frame_tot_t t;
  logic [1:0]   step;     // 0 mean, 1 rate, 2 variance
  logic [1:0]   dsel;     // division being started this cycle
  logic [2:0]   mstep;
  logic [81:0]  num_acc;  // sumsq*n, 57+25 bits
  logic [79:0]  sub_acc;  // sum*sum
  logic [49:0]  n2;
  logic [127:0] dnum;
  logic [49:0]  dden;
  logic         dstart, ddone;
  logic [127:0] q;
  logic [23:0]  mean;
  logic [16:0]  rate;
  logic [47:0]  var_q;
  logic [82:0]  diff;

  rse_divider #(.NumW(128), .DenW(50)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(q)
  );

  assign diff = {1'b0, num_acc} - 83'(sub_acc);

  always_comb begin
    state_next = state;
    case (state)
      rse_pkg::BE_IDLE: if (tot_valid) state_next = rse_pkg::BE_MUL;
      rse_pkg::BE_MUL:  if (mstep == 3'd4)
                          state_next = t.invalid ? rse_pkg::BE_OUT : rse_pkg::BE_DIV;
      rse_pkg::BE_DIV:  if (ddone && step == 2'd2) state_next = rse_pkg::BE_OUT;
      rse_pkg::BE_OUT:  if (sum_taken) state_next = rse_pkg::BE_IDLE;
      default:          state_next = rse_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != rse_pkg::BE_IDLE);
    sum_valid = (state == rse_pkg::BE_OUT);
    // a restart in BE_DIV loads the operands of the next division
    dsel      = (state == rse_pkg::BE_DIV) ? step + 2'd1 : 2'd0;
    dden      = (dsel == 2'd2) ? n2 : 50'(t.area);
    case (dsel)
      2'd0:    dnum = 128'({t.sum, 8'd0}) + 128'(t.area[24:1]);
      2'd1:    dnum = 128'({t.count, 16'd0}) + 128'(t.area[24:1]);
      default: dnum = (diff[82] || diff == '0) ? 128'd0
                      : (128'(diff) << 8) + 128'(n2[49:1]);
    endcase
    dstart = ((state == rse_pkg::BE_MUL) && (mstep == 3'd4) && !t.invalid)
          || ((state == rse_pkg::BE_DIV) && ddone && step != 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rse_pkg::BE_IDLE;
    else     state <= state_next;
  end

  // products split into two partial products each, accumulated in BE_MUL
  always_ff @(posedge clk) begin
    case (state)
      rse_pkg::BE_IDLE: begin
        if (tot_valid) t <= tot;
        mstep <= 3'd0;
        step  <= 2'd0;
      end
      rse_pkg::BE_MUL: begin
        mstep <= mstep + 3'd1;
        case (mstep)
          3'd0: begin
            num_acc <= 82'(t.sumsq[28:0]) * 82'(t.area);
            sub_acc <= 80'(t.sum[19:0]) * 80'(t.sum);
            n2      <= 50'(t.area) * 50'(t.area[12:0]);
          end
          3'd1: begin
            num_acc <= num_acc + ((82'(t.sumsq[56:29]) * 82'(t.area)) << 29);
            sub_acc <= sub_acc + ((80'(t.sum[39:20]) * 80'(t.sum)) << 20);
            n2      <= n2 + ((50'(t.area) * 50'(t.area[24:13])) << 13);
          end
          default: ;
        endcase
      end
      rse_pkg::BE_DIV: begin
        if (ddone) begin
          step <= step + 2'd1;
          case (step)
            2'd0: mean <= (q > 128'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
            2'd1: rate <= (q > 128'h1_0000) ? 17'h1_0000 : q[16:0];
            default: var_q <= (q > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q[47:0];
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sum_item                = '0;
    sum_item.is_summary     = 1'b1;
    sum_item.last           = 1'b1;
    sum_item.roi_invalid    = t.invalid;
    if (!t.invalid) begin
      sum_item.mean_q8        = mean;
      sum_item.variance_q8    = var_q;
      sum_item.mismatch_count = t.count;
      sum_item.error_rate_q16 = rate;
    end
  end
endmodule

// ===== rtl/core/roi_squared_error_statistics_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI squared error statistics core
// Squared-error map and per-frame region statistics over a pixel pair stream.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while full is low, and each gives one
// error-map transaction through the front-end register and the result queue.
// A frame_end pixel additionally gives a summary transaction after the back end
// finishes: split multiplies, then three passes of the shared serial divider
// (skipped for an invalid region). Input stalls (full) during that time, while
// a summary waits to be popped, and whenever the result queue is near full.
// ----------------------------------------------------------------------------
module roi_squared_error_statistics_core #(
  parameter int MaxDim    = rse_pkg::MaxDimDefault,
  parameter int PixelBits = rse_pkg::PixelBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rse_pkg::in_item_t  in_item,
  output logic               empty,
  input  logic               pop,
  output rse_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  logic [11:0] row_start, col_start;
  logic [12:0] row_end, col_end;
  logic        acc;
  logic        pix_valid, pix_fend, tot_valid, be_busy, sum_valid, sum_taken;
  logic [15:0] pix_sq;
  rse_pkg::frame_tot_t tot;
  rse_pkg::out_item_t  sum_item;
  rse_pkg::out_item_t  pix_item;

  // short result queue for pixel results, depth 4
  rse_pkg::out_item_t q_mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;
  logic       q_push, q_pop;
  logic [1:0] inflight;   // pixels in the front pipe
  logic       summ_pend;  // summary owes delivery after its pixel result

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_start <= rse_pkg::ROW_START_RST;
      col_start <= rse_pkg::COL_START_RST;
      row_end   <= rse_pkg::ROW_END_RST;
      col_end   <= rse_pkg::COL_END_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rse_pkg::REG_ROW_START: row_start <= cfg_data[11:0];
        rse_pkg::REG_COL_START: col_start <= cfg_data[11:0];
        rse_pkg::REG_ROW_END:   row_end   <= cfg_data;
        rse_pkg::REG_COL_END:   col_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold input in reset, while a summary is owed or the back end is busy, or when the queue could overflow
  assign full = rst || be_busy || tot_valid || summ_pend
             || (3'(cnt) + 3'(inflight) >= 3'd3);
  assign acc  = push && !full;

  rse_front #(.MaxDim(MaxDim), .PixelBits(PixelBits)) u_front (
    .clk(clk), .rst(rst), .in_valid(acc), .in_item(in_item),
    .row_start(row_start), .col_start(col_start), .row_end(row_end),
    .col_end(col_end), .pix_valid(pix_valid), .pix_sq(pix_sq),
    .pix_fend(pix_fend), .tot_valid(tot_valid), .tot(tot)
  );

  rse_back u_back (
    .clk(clk), .rst(rst), .tot_valid(tot_valid), .tot(tot), .busy(be_busy),
    .sum_valid(sum_valid), .sum_item(sum_item), .sum_taken(sum_taken)
  );

  assign q_push = pix_valid;
  assign q_pop  = pop && !empty && (cnt != 3'd0);

  // summary goes out only once all pixel results ahead of it have drained
  assign empty     = (cnt == 3'd0) && !sum_valid;
  assign sum_taken = pop && (cnt == 3'd0) && sum_valid;
  assign out_item  = (cnt != 3'd0) ? q_mem[rp] : sum_item;

  always_comb begin
    pix_item          = '0;
    pix_item.sq_error = pix_sq;
    pix_item.last     = !pix_fend;
  end

  always_ff @(posedge clk) begin
    if (q_push) q_mem[wp] <= pix_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      rp        <= '0;
      cnt       <= '0;
      inflight  <= '0;
      summ_pend <= 1'b0;
    end else begin
      if (q_push) wp <= wp + 2'd1;
      if (q_pop)  rp <= rp + 2'd1;
      cnt      <= cnt + 3'(q_push) - 3'(q_pop);
      inflight <= inflight + 2'(acc) - 2'(pix_valid);
      if (acc && in_item.frame_end) summ_pend <= 1'b1;
      else if (sum_taken)           summ_pend <= 1'b0;
    end
  end

  // the back end never takes a new frame while one is in progress
  assert property (@(posedge clk) disable iff (rst) tot_valid |-> !$past(be_busy))
    else $error("frame totals arrived while back end busy");
  // the result queue never overflows
  assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result queue overflow");
  // a summary is only offered while one is owed
  assert property (@(posedge clk) disable iff (rst) sum_valid |-> summ_pend)
    else $error("summary without frame end");
endmodule

// ===== tb/rse_stats_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI squared error statistics - stream checker
// Watches the pixel, result and register channels, predicts every result
// transaction and compares each accepted one against the oldest prediction.
// ----------------------------------------------------------------------------
module rse_stats_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  rse_pkg::in_item_t  in_item,
  input  logic               empty,
  input  logic               pop,
  input  rse_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  output int                 pending,
  output int                 errors
);
  localparam logic [23:0] MeanMax = '1;
  localparam logic [47:0] VarMax  = '1;

  logic [11:0] row_start, col_start;
  logic [12:0] row_end, col_end;
  logic [39:0] err_sum;
  logic [56:0] err_sq_sum;
  logic [24:0] diff_count;
  rse_pkg::out_item_t result_q[$];

  assign pending = result_q.size();

  task automatic predict_results(input rse_pkg::in_item_t it);
    logic [12:0]  re, ce;
    logic         in_roi;
    logic [7:0]   d;
    logic [15:0]  sq;
    logic [63:0]  area, mean, rate;
    logic [127:0] num, sub, dd, q, area2;
    rse_pkg::out_item_t px, sm;
    re = (row_end > 13'd4096) ? 13'd4096 : row_end;
    ce = (col_end > 13'd4096) ? 13'd4096 : col_end;
    in_roi = ({1'b0, it.row} >= {1'b0, row_start}) && ({1'b0, it.row} < re) &&
             ({1'b0, it.col} >= {1'b0, col_start}) && ({1'b0, it.col} < ce);
    d = (it.truth_pixel >= it.test_pixel) ? it.truth_pixel - it.test_pixel
                                          : it.test_pixel - it.truth_pixel;
    sq = in_roi ? 16'(d) * 16'(d) : 16'd0;
    if (in_roi) begin
      err_sum    = err_sum + 40'(sq);
      err_sq_sum = err_sq_sum + 57'(32'(sq) * 32'(sq));
      if (d != 0) diff_count = diff_count + 25'd1;
    end
    px = '0;
    px.sq_error = sq;
    px.last = !it.frame_end;
    result_q.push_back(px);
    if (!it.frame_end) return;

    sm = '0;
    sm.is_summary = 1'b1;
    sm.last = 1'b1;
    if (re <= {1'b0, row_start} || ce <= {1'b0, col_start}) begin
      sm.roi_invalid = 1'b1;
    end else begin
      area  = 64'(re - row_start) * 64'(ce - col_start);
      area2 = 128'(area) * 128'(area);
      mean  = (64'(err_sum) * 64'd256 + area / 2) / area;
      rate  = (64'(diff_count) * 64'd65536 + area / 2) / area;
      num   = 128'(err_sq_sum) * 128'(area);
      sub   = 128'(err_sum) * 128'(err_sum);
      if (num > sub) begin
        dd = ((num - sub) << 8) + (area2 >> 1);
        q  = dd / area2;
        sm.variance_q8 = (q > 128'(VarMax)) ? VarMax : q[47:0];
      end
      sm.mean_q8 = (mean > 64'(MeanMax)) ? MeanMax : mean[23:0];
      sm.mismatch_count = diff_count;
      sm.error_rate_q16 = (rate > 64'd65536) ? 17'd65536 : rate[16:0];
    end
    result_q.push_back(sm);
    err_sum = '0;
    err_sq_sum = '0;
    diff_count = '0;
  endtask

  task automatic compare_result(input rse_pkg::out_item_t got);
    rse_pkg::out_item_t want;
    logic      bad;
    if (result_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transaction: %p", got);
      return;
    end
    want = result_q.pop_front();
    bad = (got.is_summary !== want.is_summary) || (got.sq_error !== want.sq_error) ||
          (got.mean_q8 !== want.mean_q8) || (got.variance_q8 !== want.variance_q8) ||
          (got.mismatch_count !== want.mismatch_count) ||
          (got.error_rate_q16 !== want.error_rate_q16) ||
          (got.roi_invalid !== want.roi_invalid) || (got.last !== want.last);
    if (bad) begin
      errors++;
      if (errors <= 10) begin
        $display("result mismatch expected: %p", want);
        $display("                 actual: %p", got);
      end
    end
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    if (rst) begin
      row_start <= rse_pkg::ROW_START_RST;
      col_start <= rse_pkg::COL_START_RST;
      row_end <= rse_pkg::ROW_END_RST;
      col_end <= rse_pkg::COL_END_RST;
      err_sum = '0;
      err_sq_sum = '0;
      diff_count = '0;
    end else begin
      // check outputs first: a result can never belong to a pixel taken this edge
      if (pop && !empty) compare_result(out_item);
      if (push && !full) predict_results(in_item);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rse_pkg::REG_ROW_START: row_start <= cfg_data[11:0];
          rse_pkg::REG_COL_START: col_start <= cfg_data[11:0];
          rse_pkg::REG_ROW_END:   row_end <= cfg_data;
          rse_pkg::REG_COL_END:   col_end <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/tb_roi_squared_error_statistics_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ROI squared error statistics - testbench top
// Drives directed and random pixel frames through several region settings
// and idling phases; a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_roi_squared_error_statistics_core;
  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  rse_pkg::in_item_t  in_item;
  logic               empty;
  logic               pop;
  rse_pkg::out_item_t out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [12:0]        cfg_data;
  int                 pending;
  int                 errors;

  // idle percentages of the current phase
  int send_idle_pct;
  int recv_stall_pct;

  roi_squared_error_statistics_core u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rse_stats_checker u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: stall pop at random according to the phase.
  always @(negedge clk) begin
    pop <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Send one pixel transaction; push stays high between back-to-back items
  // and drops only while idling. Entered and left at a falling edge.
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b,
                            input logic [11:0] r, input logic [11:0] c,
                            input logic fe);
    rse_pkg::in_item_t it;
    it.truth_pixel = a;
    it.test_pixel = b;
    it.row = r;
    it.col = c;
    it.frame_end = fe;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Drain all results, hold off for the back end, then write all four registers.
  task automatic write_region(input logic [12:0] rs, input logic [12:0] cs,
                              input logic [12:0] re, input logic [12:0] ce);
    logic [12:0] vals[4];
    vals = '{rs, cs, re, ce};
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (450) @(negedge clk);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Raster scan around the region (one pixel of margin, size capped), with
  // some stray pixels; the last pixel carries frame_end unless it is a stray one.
  task automatic send_frame(input logic [11:0] rs, input logic [11:0] cs, output int sent);
    int r0, c0, rows, cols, total;
    logic [7:0] a, b;
    r0 = (rs == 0) ? 0 : rs - 1;
    c0 = (cs == 0) ? 0 : cs - 1;
    rows = $urandom_range(1, 5);
    cols = $urandom_range(1, 6);
    total = rows * cols;
    sent = 0;
    for (int k = 0; k < total; k++) begin
      a = 8'($urandom);
      b = ($urandom_range(0, 2) == 0) ? a : 8'($urandom);
      if ($urandom_range(0, 9) == 0)
        send_pixel(a, b, 12'($urandom), 12'($urandom), 1'b0);
      else
        send_pixel(a, b, 12'(r0 + k / cols), 12'(c0 + k % cols), k == total - 1);
      sent++;
    end
  endtask

  initial begin
    int count, n, phase;
    logic [11:0] rs, cs;
    logic [12:0] re, ce;
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    pop = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = rse_pkg::REG_ROW_START;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset region corners and edges
    send_pixel(8'd255, 8'd0, 12'd50, 12'd150, 1'b0);
    send_pixel(8'd0, 8'd255, 12'd449, 12'd349, 1'b0);
    send_pixel(8'd255, 8'd0, 12'd450, 12'd349, 1'b0);
    send_pixel(8'd255, 8'd0, 12'd49, 12'd150, 1'b0);
    send_pixel(8'd17, 8'd17, 12'd100, 12'd200, 1'b0);
    send_pixel(8'd0, 8'd0, 12'd0, 12'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 12'd4095, 12'd4095, 1'b1);

    // Single-pixel region at the far corner; repeats saturate the mean
    write_region(13'd4095, 13'd4095, 13'd4096, 13'd4096);
    send_pixel(8'd0, 8'd255, 12'd4095, 12'd4095, 1'b0);
    send_pixel(8'd255, 8'd0, 12'd4095, 12'd4095, 1'b0);
    send_pixel(8'd3, 8'd255, 12'd4095, 12'd4095, 1'b1);

    // Ends beyond the image are clamped; start fields ignore bit 12
    write_region(13'h1000, 13'h1000, 13'h1FFF, 13'h1FFF);
    send_pixel(8'd1, 8'd2, 12'd0, 12'd0, 1'b0);
    send_pixel(8'd200, 8'd10, 12'd4095, 12'd0, 1'b0);
    send_pixel(8'd9, 8'd9, 12'd2048, 12'd4095, 1'b1);

    // Inverted region, then empty region
    write_region(13'd100, 13'd100, 13'd50, 13'd200);
    send_pixel(8'd5, 8'd7, 12'd60, 12'd150, 1'b1);
    write_region(13'd0, 13'd0, 13'd0, 13'd0);
    send_pixel(8'd128, 8'd127, 12'd0, 12'd0, 1'b1);

    // Random phases: cycle through the idling modes
    count = 0;
    phase = 0;
    while (count < 1900) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      rs = 12'($urandom);
      cs = 12'($urandom);
      case ($urandom_range(0, 5))
        0: begin re = 13'($urandom); ce = 13'($urandom); end
        1: begin re = {1'b0, rs}; ce = 13'(cs) + 13'd2; end
        default: begin
          re = 13'(rs) + 13'($urandom_range(1, 4));
          ce = 13'(cs) + 13'($urandom_range(1, 5));
        end
      endcase
      write_region({1'($urandom), rs}, {1'($urandom), cs}, re, ce);
      for (int f = 0; f < 8 && count < 1900; f++) begin
        send_frame(rs, cs, n);
        count += n;
      end
      phase++;
    end

    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (450) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("roi_squared_error_statistics_core: match");
    end else begin
      $display("roi_squared_error_statistics_core: mismatch");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("roi_squared_error_statistics_core: mismatch");
    $finish;
  end
endmodule

// ===== roi_squared_error_statistics_core.f =====
rtl/core/rse_pkg.sv
rtl/core/rse_divider.sv
rtl/core/rse_front.sv
rtl/core/rse_back.sv
rtl/core/roi_squared_error_statistics_core.sv
tb/rse_stats_checker.sv
tb/tb_roi_squared_error_statistics_core.sv
